@@ sv/sgpa_pkg.sv @@
// Shared types and constants of the softened gravity pair accumulator.
// Depends on nothing; the top level imports it.
package sgpa_pkg;

	// Configuration register indexes.
	localparam logic REG_GAIN      = 1'b0;
	localparam logic REG_SOFTENING = 1'b1;

	// Reset value of the gain register.
	localparam logic [31:0] GAIN_RESET = 32'h0001_0000;

	// Normalizer width: a 64-bit value sits two bits up so that the
	// 66-bit squared distance uses the same shifter.
	localparam int NormW = 66;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ,
		S_RLOAD,
		S_NORM,
		S_RDONE,
		S_SQRT,
		S_DMUL,
		S_DLOAD,
		S_DDONE,
		S_GMUL,
		S_GLOAD,
		S_GDONE,
		S_MDONE,
		S_NLOAD,
		S_NDONE,
		S_AXIS,
		S_ADONE,
		S_PLOAD,
		S_PDONE,
		S_DIV,
		S_ACC,
		S_FIN
	} state_t;

endpackage

@@ sv/softened_gravity_pair_accumulator.sv @@
// Softened direct-sum gravity pair accumulator: sequencer and shared datapath.
// Depends on sgpa_pkg for the state type and register indexes.
//
// Channel  Direction  Handshake              Payload
// in       request    in_valid / in_ready    target_*, source_*, masses, last_source
// out      result     out_valid / out_ready  total_x/y/z, overflowed
// cfg      write      cfg_write              cfg_index, cfg_data
//
// No new pair is taken until the current one is finished. A pair with zero
// separation skips all arithmetic; a zero gain or mass skips the numerator and
// the divisions, and each zero axis skips its normalization and division. The
// shared normalizer (up to 11 uses), the one-bit-per-cycle square root and
// divider are run by one sequencer around a single 33x33 multiplier.
// Reset clears the sums, the overflow flag and softening; gain gets GAIN_RESET.
// A result waiting at the output stalls only a pair that is flagged last.
module softened_gravity_pair_accumulator
	import sgpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [62:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic [31:0]        target_mass,
	input  logic signed [31:0] source_x,
	input  logic signed [31:0] source_y,
	input  logic signed [31:0] source_z,
	input  logic [31:0]        source_mass,
	input  logic               last_source,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] total_x,
	output logic signed [63:0] total_y,
	output logic signed [63:0] total_z,
	output logic               overflowed
);

	localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
	localparam logic [63:0] MAX_NEG = {1'b1, {63{1'b0}}};

	state_t state_q, state_d, ret_q;

	logic [31:0]        gain_q;
	logic [62:0]        soft_q;

	logic [5:0]         cnt_q;
	logic [2:0]         ncnt_q;
	logic [NormW-1:0]   n_q;
	logic [6:0]         lz_q;
	logic [65:0]        p_q;
	logic [65:0]        r_q;
	logic [32:0]        ad_q [3];
	logic [2:0]         neg_q;
	logic [1:0]         k_q;
	logic [31:0]        m_q;
	logic signed [9:0]  er_q;
	logic [63:0]        x_q;
	logic [63:0]        res_q;
	logic [31:0]        den_m_q;
	logic signed [9:0]  den_e_q;
	logic [31:0]        num_m_q;
	logic signed [9:0]  num_e_q;
	logic               have_num_q;
	logic [31:0]        mt_q;
	logic [31:0]        ms_q;
	logic               last_q;
	logic signed [9:0]  te_q;
	logic [33:0]        rem_q;
	logic [32:0]        q_q;
	logic               zero_q;
	logic [63:0]        sum_q [3];
	logic               sat_q;
	logic               out_valid_q;

	// Accept-time differences and their magnitudes.
	logic signed [32:0] dx, dy, dz;
	logic [32:0]        ax, ay, az;

	always_comb begin
		dx = {source_x[31], source_x} - {target_x[31], target_x};
		dy = {source_y[31], source_y} - {target_y[31], target_y};
		dz = {source_z[31], source_z} - {target_z[31], target_z};
		ax = dx[32] ? 33'(-dx) : 33'(dx);
		ay = dy[32] ? 33'(-dy) : 33'(dy);
		az = dz[32] ? 33'(-dz) : 33'(dz);
	end

	// Normalizer step: shift left by the current power of two when the top
	// bits are all zero.
	logic [6:0]         nsh;
	logic               ntop_zero;
	logic [31:0]        ntop;
	logic signed [9:0]  nexp;

	always_comb begin
		nsh       = 7'd1 << ncnt_q;
		ntop_zero = (n_q >> (7'd66 - nsh)) == '0;
		ntop      = n_q[65:34];
		nexp      = 10'sd32 - $signed({3'b000, lz_q});
	end

	// Square root step.
	logic [63:0] sq_bit, sq_sum;

	always_comb begin
		sq_bit = 64'd1 << {cnt_q[4:0], 1'b0};
		sq_sum = res_q + sq_bit;
	end

	// Divider step.
	logic        div_ge;
	logic [33:0] div_r;

	always_comb begin
		div_ge = rem_q >= {2'b00, den_m_q};
		div_r  = div_ge ? rem_q - {2'b00, den_m_q} : rem_q;
	end

	// Term shift, sign and saturating accumulation.
	logic [63:0] mag, term, acc_sum, acc_new;
	logic        term_sat, acc_ovf;
	logic [9:0]  te_neg;

	always_comb begin
		te_neg   = 10'(-te_q);
		term_sat = 1'b0;
		if (zero_q) begin
			mag = '0;
		end else if (te_q >= 10'sd31) begin
			mag      = MAX_POS;
			term_sat = 1'b1;
		end else if (te_q >= 10'sd0) begin
			mag = {31'b0, q_q} << te_q[4:0];
		end else if (te_q > -10'sd64) begin
			mag = {31'b0, q_q} >> te_neg[5:0];
		end else begin
			mag = '0;
		end
		term    = neg_q[k_q] ? 64'(-mag) : mag;
		acc_sum = sum_q[k_q] + term;
		acc_ovf = (sum_q[k_q][63] == term[63]) && (acc_sum[63] != term[63]);
		acc_new = acc_ovf ? (term[63] ? MAX_NEG : MAX_POS) : acc_sum;
	end

	// Shared multiplier operand selection.
	logic        mul_en;
	logic [32:0] mul_a, mul_b;

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_SQ: begin
				if (cnt_q < 6'd3) begin
					mul_en = 1'b1;
					mul_a  = ad_q[cnt_q[1:0]];
					mul_b  = ad_q[cnt_q[1:0]];
				end
			end
			S_DMUL: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, m_q};
				mul_b  = {1'b0, res_q[31:0]};
			end
			S_GMUL: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, gain_q};
				mul_b  = {1'b0, mt_q};
			end
			S_MDONE, S_ADONE: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, num_m_q};
				mul_b  = {1'b0, ntop};
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (dx == '0 && dy == '0 && dz == '0) ? S_FIN : S_SQ;
				end
			end
			S_SQ:    if (cnt_q == 6'd3) state_d = S_RLOAD;
			S_RLOAD: state_d = S_NORM;
			S_NORM:  if (ncnt_q == 3'd0) state_d = ret_q;
			S_RDONE: state_d = S_SQRT;
			S_SQRT:  if (cnt_q == 6'd0) state_d = S_DMUL;
			S_DMUL:  state_d = S_DLOAD;
			S_DLOAD: state_d = S_NORM;
			S_DDONE: state_d = have_num_q ? S_GMUL : S_AXIS;
			S_GMUL:  state_d = S_GLOAD;
			S_GLOAD: state_d = S_NORM;
			S_GDONE: state_d = S_NORM;
			S_MDONE: state_d = S_NLOAD;
			S_NLOAD: state_d = S_NORM;
			S_NDONE: state_d = S_AXIS;
			S_AXIS: begin
				state_d = (ad_q[k_q] == '0 || !have_num_q) ? S_ACC : S_NORM;
			end
			S_ADONE: state_d = S_PLOAD;
			S_PLOAD: state_d = S_NORM;
			S_PDONE: state_d = S_DIV;
			S_DIV:   if (cnt_q == 6'd0) state_d = S_ACC;
			S_ACC:   state_d = (k_q == 2'd2) ? S_FIN : S_AXIS;
			S_FIN: begin
				if (!last_q || !out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			soft_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAIN:      gain_q <= cfg_data[31:0];
				REG_SOFTENING: soft_q <= cfg_data;
				default:       gain_q <= gain_q;
			endcase
		end
	end

	// Accumulators, overflow flag and output register.
	logic fin_load;
	assign fin_load = state_q == S_FIN && last_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			sum_q[2]    <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_ACC) begin
				sum_q[k_q] <= acc_new;
				if (term_sat || acc_ovf) begin
					sat_q <= 1'b1;
				end
			end
			if (fin_load) begin
				sum_q[0]    <= '0;
				sum_q[1]    <= '0;
				sum_q[2]    <= '0;
				sat_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			total_x    <= sum_q[0];
			total_y    <= sum_q[1];
			total_z    <= sum_q[2];
			overflowed <= sat_q;
		end
	end

	assign out_valid = out_valid_q;

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q  <= S_IDLE;
			cnt_q  <= '0;
			ncnt_q <= '0;
			k_q    <= '0;
			last_q <= 1'b0;
		end else begin
			if (mul_en) begin
				p_q <= mul_a * mul_b;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ad_q[0]    <= ax;
						ad_q[1]    <= ay;
						ad_q[2]    <= az;
						neg_q      <= {dz[32], dy[32], dx[32]};
						mt_q       <= target_mass;
						ms_q       <= source_mass;
						last_q     <= last_source;
						have_num_q <= gain_q != '0 && target_mass != '0
							&& source_mass != '0;
						r_q        <= {3'b000, soft_q};
						cnt_q      <= '0;
					end
				end
				S_SQ: begin
					if (cnt_q != 6'd0) begin
						r_q <= r_q + p_q;
					end
					cnt_q <= cnt_q + 6'd1;
				end
				S_RLOAD: begin
					n_q    <= r_q;
					lz_q   <= '0;
					ncnt_q <= 3'd6;
					ret_q  <= S_RDONE;
				end
				S_NORM: begin
					if (ntop_zero) begin
						n_q  <= n_q << nsh;
						lz_q <= lz_q + nsh;
					end
					ncnt_q <= ncnt_q - 3'd1;
				end
				S_RDONE: begin
					m_q   <= lz_q[0] ? {1'b0, n_q[65:35]} : n_q[65:34];
					x_q   <= lz_q[0] ? {1'b0, n_q[65:35], 32'b0} : {n_q[65:34], 32'b0};
					er_q  <= 10'sd34 - $signed({3'b000, lz_q}) + $signed({9'b0, lz_q[0]});
					res_q <= '0;
					cnt_q <= 6'd31;
				end
				S_SQRT: begin
					if (x_q >= sq_sum) begin
						x_q   <= x_q - sq_sum;
						res_q <= (res_q >> 1) + sq_bit;
					end else begin
						res_q <= res_q >> 1;
					end
					cnt_q <= cnt_q - 6'd1;
				end
				S_DLOAD, S_GLOAD, S_NLOAD, S_PLOAD: begin
					n_q    <= {p_q[63:0], 2'b00};
					lz_q   <= '0;
					ncnt_q <= 3'd6;
					case (state_q)
						S_DLOAD: ret_q <= S_DDONE;
						S_GLOAD: ret_q <= S_GDONE;
						S_NLOAD: ret_q <= S_NDONE;
						default: ret_q <= S_PDONE;
					endcase
				end
				S_DDONE: begin
					den_m_q <= ntop;
					den_e_q <= nexp + er_q + (er_q >>> 1) - 10'sd16;
					k_q     <= '0;
				end
				S_GDONE: begin
					num_m_q <= ntop;
					num_e_q <= nexp;
					n_q     <= {32'b0, ms_q, 2'b00};
					lz_q    <= '0;
					ncnt_q  <= 3'd6;
					ret_q   <= S_MDONE;
				end
				S_MDONE: begin
					num_e_q <= num_e_q + nexp;
				end
				S_NDONE: begin
					num_m_q <= ntop;
					num_e_q <= num_e_q + nexp + 10'sd16;
				end
				S_AXIS: begin
					zero_q <= ad_q[k_q] == '0 || !have_num_q;
					n_q    <= {31'b0, ad_q[k_q], 2'b00};
					lz_q   <= '0;
					ncnt_q <= 3'd6;
					ret_q  <= S_ADONE;
				end
				S_ADONE: begin
					te_q <= num_e_q + nexp;
				end
				S_PDONE: begin
					rem_q <= {2'b00, ntop};
					q_q   <= '0;
					te_q  <= te_q + nexp - den_e_q - 10'sd32;
					cnt_q <= 6'd32;
				end
				S_DIV: begin
					q_q   <= {q_q[31:0], div_ge};
					rem_q <= {div_r[32:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
				end
				S_ACC: begin
					k_q <= k_q + 2'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// The block takes no new pair until the current one is finished.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pair accepted while busy");

	// A result appears only from a finishing pair flagged last.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN && last_q))
		else $error("result without a last pair");

	// The square root of a 64-bit value fits in 32 bits.
	a_sqrt_width: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DMUL |-> res_q[63:32] == '0)
		else $error("square root out of range");

endmodule

@@ dv/tb_softened_gravity_pair_accumulator.sv @@
// Self-checking testbench for the softened gravity pair accumulator.
// It drives body pairs through the request channel and checks each force total against
// a bit-exact fixed-point predictor, or a given total for typed rows. It depends on sgpa_pkg and the top level.
module tb_softened_gravity_pair_accumulator;
	import sgpa_pkg::*;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;
	localparam int SETTLE = 300;

	typedef struct {
		logic signed [31:0] tx, ty, tz;
		logic [31:0]        tm;
		logic signed [31:0] sx, sy, sz;
		logic [31:0]        sm;
		logic               last;
	} pair_t;

	typedef struct {
		logic signed [63:0] fx, fy, fz;
		logic               ovf;
	} force_t;

	typedef struct {
		logic [63:0] m;
		int          e;
	} fp_t;

	typedef enum logic [1:0] {ROW_PAIR, ROW_GAIN, ROW_SOFT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		pair_t       p;
		logic [62:0] value;
		bit          typed;
		force_t      want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = REG_GAIN;
	logic [62:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
	logic [31:0] target_mass = '0;
	logic signed [31:0] source_x = '0, source_y = '0, source_z = '0;
	logic [31:0] source_mass = '0;
	logic last_source = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] total_x, total_y, total_z;
	logic overflowed;

	// Predictor state and the store of pending force totals.
	logic [31:0] gain_q16 = GAIN_RESET;
	logic [62:0] soft_sq = '0;
	logic [63:0] acc_x = '0, acc_y = '0, acc_z = '0;
	bit          acc_sat = 0;
	force_t      pending_totals[$];
	row_t        rows[$];
	bit          failed = 0;
	int          send_idle = 0;
	int          recv_stall = 0;

	softened_gravity_pair_accumulator DUT (.*);

	always #4 clk = ~clk;

	// Appends one row to the directed stimulus table.
	function automatic void add_row(row_t r);
		rows.insert(rows.size(), r);
	endfunction

	// Fixed-point helpers for the force predictor.
	function automatic int top_bit(logic [127:0] v);
		for (int i = 127; i > 0; i--)
			if (v[i]) return i;
		return 0;
	endfunction

	function automatic fp_t fp_norm(logic [63:0] v);
		fp_t r;
		int  b;
		b = top_bit({64'b0, v});
		r.e = b - 31;
		r.m = (b >= 31) ? (v >> (b - 31)) : (v << (31 - b));
		return r;
	endfunction

	function automatic fp_t fp_mul(fp_t a, fp_t b);
		fp_t p;
		p = fp_norm(a.m * b.m);
		p.e += a.e + b.e;
		return p;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'h1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63]) begin
			acc_sat = 1;
			r = a[63] ? NEG_MAX : POS_MAX;
		end
		return r;
	endfunction

	// One axis term: sign of d times num*|d|/den, shifted and clamped.
	function logic [63:0] axis_force(longint d, bit have, fp_t num, fp_t den);
		fp_t         n;
		logic [63:0] q, mag;
		int          qe;
		if (d == 0 || !have) return 0;
		n = fp_mul(num, fp_norm(d < 0 ? -d : d));
		q = (n.m << 32) / den.m;
		qe = n.e - den.e - 32;
		if (qe >= 31) begin
			acc_sat = 1;
			mag = POS_MAX;
		end else if (qe >= 0) begin
			mag = q << qe;
			if (mag > POS_MAX) begin
				acc_sat = 1;
				mag = POS_MAX;
			end
		end else if (qe > -64) begin
			mag = q >> (-qe);
		end else begin
			mag = 0;
		end
		return d < 0 ? -mag : mag;
	endfunction

	// Accumulates one pair; returns 1 with the totals when the pair closes a target.
	function bit accumulate_pair(pair_t p, output force_t f);
		longint       dx, dy, dz;
		logic [127:0] r2;
		logic [63:0]  m, sq;
		int           e;
		fp_t          num, den;
		bit           have;
		dx = longint'(p.sx) - longint'(p.tx);
		dy = longint'(p.sy) - longint'(p.ty);
		dz = longint'(p.sz) - longint'(p.tz);
		if (dx != 0 || dy != 0 || dz != 0) begin
			// Squares are formed at full width; a 64-bit product would wrap.
			r2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz)
				+ 128'(soft_sq);
			e = top_bit(r2) - 31;
			if (e % 2 != 0) e++;
			m = (e >= 0) ? 64'(r2 >> e) : 64'(r2 << (-e));
			sq = int_sqrt(m << 32);
			den = fp_norm(m * sq);
			den.e += e + e / 2 - 16;
			have = gain_q16 != 0 && p.tm != 0 && p.sm != 0;
			num = '{m: 0, e: 0};
			if (have) begin
				num = fp_mul(fp_norm(64'(gain_q16) * 64'(p.tm)), fp_norm(64'(p.sm)));
				num.e += 16;
			end
			acc_x = clamp_add(acc_x, axis_force(dx, have, num, den));
			acc_y = clamp_add(acc_y, axis_force(dy, have, num, den));
			acc_z = clamp_add(acc_z, axis_force(dz, have, num, den));
		end
		f = '{fx: acc_x, fy: acc_y, fz: acc_z, ovf: acc_sat};
		if (!p.last) return 0;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		acc_sat = 0;
		return 1;
	endfunction

	// Presents one request, holds it until accepted, then predicts its result.
	task automatic send_pair(pair_t p, bit typed = 0, force_t want = '{default: 0});
		force_t f;
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		target_x <= p.tx; target_y <= p.ty; target_z <= p.tz; target_mass <= p.tm;
		source_x <= p.sx; source_y <= p.sy; source_z <= p.sz; source_mass <= p.sm;
		last_source <= p.last;
		do @(posedge clk); while (!in_ready);
		if (accumulate_pair(p, f))
			pending_totals.insert(pending_totals.size(), typed ? want : f);
		@(negedge clk);
	endtask

	// Register writes happen only once the block has drained.
	task automatic write_reg(logic idx, logic [62:0] value);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_GAIN) gain_q16 = value[31:0];
		else soft_sq = value;
	endtask

	function automatic logic [31:0] coord(bit narrow);
		return narrow ? 32'($urandom_range(0, 2 * 1048576) - 1048576) : 32'($urandom);
	endfunction

	function automatic logic [31:0] mass(bit narrow);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) return 0;
		return narrow ? 32'($urandom_range(1, 32'h0004_0000)) : 32'($urandom);
	endfunction

	// Receiver back-pressure.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall);

	// Compares each accepted result with the oldest pending total.
	always @(posedge clk) begin
		force_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_totals.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h ovf=%b",
					$time, total_x, total_y, total_z, overflowed);
				failed = 1;
			end else begin
				w = pending_totals.pop_front();
				if (total_x !== w.fx) begin
					$display("%0t: total_x expected %h actual %h", $time, w.fx, total_x);
					failed = 1;
				end
				if (total_y !== w.fy) begin
					$display("%0t: total_y expected %h actual %h", $time, w.fy, total_y);
					failed = 1;
				end
				if (total_z !== w.fz) begin
					$display("%0t: total_z expected %h actual %h", $time, w.fz, total_z);
					failed = 1;
				end
				if (overflowed !== w.ovf) begin
					$display("%0t: overflowed expected %b actual %b", $time, w.ovf, overflowed);
					failed = 1;
				end
			end
		end
	end

	initial begin
		#(8 * 3000000);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		pair_t  p, tgt;
		force_t zero;
		int     group_len;
		logic [31:0] gains[5];
		logic [62:0] softs[5];
		int     stalls[5][2];
		bit     narrow;

		zero = '{default: 0};
		// Directed rows: zero cases, extremes, each axis, and both registers.
		add_row('{ROW_PAIR, '{5, -7, 9, 32'hFFFF_FFFF, 5, -7, 9, 32'hFFFF_FFFF, 1},
			0, 1, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 1}, 0, 1, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 1}, 0, 1, zero});
		add_row('{ROW_PAIR, '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'hFFFF_FFFF, 1}, 0, 0, zero});
		add_row('{ROW_PAIR, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'hFFFF_FFFF, 1}, 0, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 32'hFFFF_FFFF, 1},
			0, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 0},
			0, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'h10000, 0, -32'sh20000, 0, 32'h20000, 0},
			0, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'h10000, 0, 0, 32'h30000, 32'h8000, 1},
			0, 0, zero});
		add_row('{ROW_PAIR, '{1, 2, 3, 32'h1, -1, -2, -3, 32'h1, 1}, 0, 0, zero});
		add_row('{ROW_GAIN, '{default: 0}, 63'h0, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 1},
			0, 1, zero});
		add_row('{ROW_GAIN, '{default: 0}, 63'hFFFF_FFFF, 0, zero});
		add_row('{ROW_SOFT, '{default: 0}, {63{1'b1}}, 0, zero});
		add_row('{ROW_PAIR, '{-4, 4, -4, 32'hFFFF_FFFF, -4, 4, -4, 32'hFFFF_FFFF, 1},
			0, 1, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'hFFFF_FFFF, 32'h10000, 32'h10000, 0,
			32'hFFFF_FFFF, 1}, 0, 0, zero});
		add_row('{ROW_SOFT, '{default: 0}, 63'h1_0000_0000, 0, zero});
		add_row('{ROW_PAIR, '{0, 0, 0, 32'hFFFF_FFFF, 32'h10, 0, 0, 32'hFFFF_FFFF, 1},
			0, 0, zero});

		gains = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 32'h0000_4000, 32'h0009_8000};
		softs = '{63'h0, {63{1'b1}}, 63'h0, 63'h1_0000, 63'h4_0000_0000};
		stalls = '{'{0, 0}, '{83, 0}, '{0, 83}, '{34, 34}, '{0, 0}};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_GAIN: write_reg(REG_GAIN, rows[i].value);
				ROW_SOFT: write_reg(REG_SOFTENING, rows[i].value);
				default: send_pair(rows[i].p, rows[i].typed, rows[i].want);
			endcase
		end

		// Random phases: one target against a run of sources, ending on the last flag.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_GAIN, ph == 3 ? 63'($urandom) : 63'(gains[ph]));
			write_reg(REG_SOFTENING, ph == 3 ? {31'($urandom), 32'($urandom)} : softs[ph]);
			send_idle = stalls[ph][0];
			recv_stall = stalls[ph][1];
			for (int n = 0; n < 163; n += group_len) begin
				narrow = $urandom_range(0, 3) != 0;
				tgt.tx = coord(narrow); tgt.ty = coord(narrow); tgt.tz = coord(narrow);
				tgt.tm = mass(narrow);
				group_len = $urandom_range(1, 8);
				for (int k = 0; k < group_len; k++) begin
					p = tgt;
					if ($urandom_range(0, 9) != 0) begin
						p.sx = coord(narrow); p.sy = coord(narrow); p.sz = coord(narrow);
					end else begin
						p.sx = tgt.tx; p.sy = tgt.ty; p.sz = tgt.tz;
					end
					p.sm = mass(narrow);
					p.last = (k == group_len - 1) || ($urandom_range(0, 19) == 0);
					if ($urandom_range(0, 14) == 0)
						p.tx = coord(0);
					send_pair(p);
				end
			end
		end

		// Drain and let the block settle before the verdict.
		in_valid <= 1'b0;
		while (pending_totals.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
